>>> hdl/mgof_pkg.sv
package mgof_pkg;

   localparam int WINDOW_LEN_DEF  = 10;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int               BAND_BITS  = 15;
   localparam logic [BAND_BITS-1:0] BAND_RESET = 15'd2859;

   // outcome of one word against the current window
   typedef struct packed {
      logic filling;
      logic passed;
   } mgof_verdict_type;

endpackage

>>> hdl/mgof_ifs.sv
interface mgof_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mgof_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          passed;
   logic signed [SAMPLE_BITS-1:0] held_value;

   modport source (output valid, output passed, output held_value, input ready);
   modport sink   (input valid, input passed, input held_value, output ready);
endinterface

interface mgof_csr_if;
   import mgof_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BAND_BITS-1:0] band_threshold;

   modport source (output valid, output band_threshold, input ready);
   modport sink   (input valid, input band_threshold, output ready);
endinterface

>>> hdl/median_gate_outlier_filter.sv
// Median-gated outlier filter.
// req_ch carries one signed Q2.13 word per transfer (field sample); rsp_ch
// returns one word per input: passed and held_value. csr_ch writes the
// acceptance half width band_threshold; it is always ready and is meant to
// be written only while no word is in flight.
// The first WINDOW_LEN words fill the window and come back with passed low.
// After that each word is compared with the upper median of the window,
// found by parallel rank compares in the same cycle as the window update.
// Path: a word taken on req_ch passes the input register, then the result
// register, and is shown on rsp_ch from there (two register stages).
// Throughput: one word per cycle while rsp_ch is not stalled; the window
// update loop closes combinationally through the rank compares and band check.
// Stall: when rsp_ch.ready is low the result register holds, the input
// register keeps its word or takes one more if empty, then req_ch.ready drops.
// Reset (synchronous, active high): window and fill count clear to zero,
// held value to zero, band_threshold to its default; both stages empty.
module median_gate_outlier_filter
   import mgof_pkg::*;
#(
   parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mgof_req_if.sink  req_ch,
   mgof_rsp_if.source rsp_ch,
   mgof_csr_if.sink  csr_ch
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_passed_ff, rsp_passed_in;
   logic [SAMPLE_BITS-1:0] rsp_held_ff, rsp_held_in;
   logic [SAMPLE_BITS-1:0] held_ff, held_in;
   logic [BAND_BITS-1:0]   band_ff, band_in;
   logic                   rsp_load, step, req_take;
   mgof_verdict_type       verdict;

   assign rsp_load = !rsp_valid_ff || rsp_ch.ready;
   assign step     = s1_valid_ff && rsp_load;
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready      = !s1_valid_ff || rsp_load;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.passed     = rsp_passed_ff;
   assign rsp_ch.held_value = rsp_held_ff;
   assign csr_ch.ready      = 1'b1;

   mgof_window #(
      .WINDOW_LEN (WINDOW_LEN),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .sample (s1_sample_ff),
      .band   (band_ff),
      .verdict(verdict)
   );

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_sample_in  = s1_sample_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_passed_in = rsp_passed_ff;
      rsp_held_in   = rsp_held_ff;
      held_in       = held_ff;
      band_in       = band_ff;

      if (req_take) begin
         s1_valid_in  = 1'b1;
         s1_sample_in = req_ch.sample;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end

      if (step) begin
         rsp_valid_in  = 1'b1;
         rsp_passed_in = verdict.passed;
         if (verdict.filling || verdict.passed) begin
            held_in     = s1_sample_ff;
            rsp_held_in = s1_sample_ff;
         end else begin
            rsp_held_in = held_ff;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_ch.valid) begin
         band_in = csr_ch.band_threshold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
         band_ff      <= BAND_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         band_ff      <= band_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff  <= s1_sample_in;
      rsp_passed_ff <= rsp_passed_in;
      rsp_held_ff   <= rsp_held_in;
   end

endmodule

>>> hdl/mgof_median.sv
module mgof_median
   import mgof_pkg::*;
#(
   parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] window,
   output logic [SAMPLE_BITS-1:0]                 median
);

   localparam int CNT_BITS = $clog2(WINDOW_LEN + 1);
   localparam logic [CNT_BITS-1:0] MED_RANK = CNT_BITS'(WINDOW_LEN / 2);

   logic [WINDOW_LEN-1:0][CNT_BITS-1:0] lt_cnt;
   logic [WINDOW_LEN-1:0][CNT_BITS-1:0] le_cnt;
   logic [WINDOW_LEN-1:0]               is_med;

   // rank of each entry by parallel compares; ties all select the same value
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         lt_cnt[i] = '0;
         le_cnt[i] = '0;
         for (int j = 0; j < WINDOW_LEN; j++) begin
            if ($signed(window[j]) < $signed(window[i])) begin
               lt_cnt[i] = lt_cnt[i] + CNT_BITS'(1);
            end
            if ($signed(window[j]) <= $signed(window[i])) begin
               le_cnt[i] = le_cnt[i] + CNT_BITS'(1);
            end
         end
         is_med[i] = (lt_cnt[i] <= MED_RANK) && (le_cnt[i] > MED_RANK);
      end
   end

   always_comb begin
      median = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (is_med[i]) begin
            median = median | window[i];
         end
      end
   end

endmodule

>>> hdl/mgof_window.sv
module mgof_window
   import mgof_pkg::*;
#(
   parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [BAND_BITS-1:0]   band,
   output mgof_verdict_type       verdict
);

   localparam int IDX_BITS  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_BITS  = $clog2(WINDOW_LEN + 1);
   localparam int WIDE_BITS =
      ((SAMPLE_BITS > BAND_BITS) ? SAMPLE_BITS : BAND_BITS + 1) + 2;
   localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(WINDOW_LEN);

   logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] win_ff, win_in;
   logic [CNT_BITS-1:0]                    fill_ff, fill_in;
   logic [SAMPLE_BITS-1:0]                 median;
   logic signed [WIDE_BITS-1:0]            med_w, thr_w, x_w, lo_w, hi_w;
   logic                                   filling, passed;
   logic [IDX_BITS-1:0]                    fill_idx;

   mgof_median #(
      .WINDOW_LEN (WINDOW_LEN),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_median (
      .window(win_ff),
      .median(median)
   );

   assign filling  = (fill_ff != FULL);
   assign fill_idx = fill_ff[IDX_BITS-1:0];

   assign med_w = {{(WIDE_BITS-SAMPLE_BITS){median[SAMPLE_BITS-1]}}, median};
   assign x_w   = {{(WIDE_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
   assign thr_w = {{(WIDE_BITS-BAND_BITS){1'b0}}, band};
   assign lo_w  = med_w - thr_w;
   assign hi_w  = med_w + thr_w;

   assign passed = !filling && (x_w > lo_w) && (x_w < hi_w);

   assign verdict.filling = filling;
   assign verdict.passed  = passed;

   always_comb begin
      fill_in = fill_ff;
      win_in  = win_ff;
      if (step) begin
         if (filling) begin
            fill_in = fill_ff + CNT_BITS'(1);
            for (int i = 0; i < WINDOW_LEN; i++) begin
               if (fill_idx == IDX_BITS'(i)) begin
                  win_in[i] = sample;
               end
            end
         end else if (passed) begin
            // shift toward the oldest end, append as newest
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[WINDOW_LEN-1] = sample;
         end else begin
            win_in[WINDOW_LEN-1] = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         win_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         win_ff  <= win_in;
      end
   end

endmodule
